### hw/rtl/ftvp_pkg.sv
// Shared constants and the result record type of the FIX tag=value parser.
`timescale 1ns / 1ps
package ftvp_pkg;

  localparam int MAX_MESSAGE_BYTES = 4096;
  localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);

  localparam int TAG_W    = 31;
  localparam int OFFSET_W = 12;
  localparam int LEN_W    = 13;
  localparam int NUM_W    = 32;

  localparam logic [TAG_W-1:0] TAG_MAX      = 31'h7FFF_FFFF;
  localparam logic [TAG_W-1:0] TAG_BEGIN    = 31'd8;
  localparam logic [TAG_W-1:0] TAG_BODY_LEN = 31'd9;
  localparam logic [TAG_W-1:0] TAG_MSG_TYPE = 31'd35;
  localparam logic [TAG_W-1:0] TAG_CHECKSUM = 31'd10;

  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic KIND_FIELD  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NO_BEGIN     = 3'd1;
  localparam logic [2:0] ST_NO_BODY_LEN  = 3'd2;
  localparam logic [2:0] ST_BAD_FORMAT   = 3'd3;
  localparam logic [2:0] ST_BAD_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_NO_CHECKSUM  = 3'd5;

  localparam int Q_DEPTH = 4;
  localparam int Q_IDX_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic                    record_kind;
    logic [TAG_W-1:0]        field_tag;
    logic [OFFSET_W-1:0]     value_offset;
    logic [LEN_W-1:0]        value_length;
    logic signed [NUM_W-1:0] value_number;
    logic                    number_ok;
    logic [2:0]              status;
    logic signed [NUM_W-1:0] stated_length;
    logic [7:0]              computed_checksum;
    logic signed [NUM_W-1:0] received_checksum;
    logic                    last_result;
  } rec_t;

endpackage

### hw/rtl/ftvp_byte_if.sv
// Byte channel into the parser: valid/ready handshake with one message byte per beat.
`timescale 1ns / 1ps
interface ftvp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

### hw/rtl/ftvp_rec_if.sv
// Record channel out of the parser: valid/ready handshake with one record per beat.
`timescale 1ns / 1ps
interface ftvp_rec_if;
  logic               valid;
  logic               ready;
  logic               record_kind;
  logic [30:0]        field_tag;
  logic [11:0]        value_offset;
  logic [12:0]        value_length;
  logic signed [31:0] value_number;
  logic               number_ok;
  logic [2:0]         status;
  logic signed [31:0] stated_length;
  logic [7:0]         computed_checksum;
  logic signed [31:0] received_checksum;
  logic               last_result;

  modport source (
    output valid, output record_kind, output field_tag, output value_offset,
    output value_length, output value_number, output number_ok, output status,
    output stated_length, output computed_checksum, output received_checksum,
    output last_result, input ready
  );
  modport sink (
    input valid, input record_kind, input field_tag, input value_offset,
    input value_length, input value_number, input number_ok, input status,
    input stated_length, input computed_checksum, input received_checksum,
    input last_result, output ready
  );
endinterface

### hw/rtl/fix_tag_value_parser.sv
// FIX tag=value parser top level: field splitter, header checks, checksum and record queue.
// A record is registered into the record queue when the byte beat that completes it is taken.
// Throughput: one byte per cycle while msg.ready is high; a byte that yields two records
// pushes both into the queue. A four-entry record queue takes bytes while it has room for
// two records, so input stalls only when three or more records wait on a stalled output.
// Reset (rst, synchronous) clears the parser state and empties the record queue.
`timescale 1ns / 1ps
module fix_tag_value_parser
  import ftvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ftvp_byte_if.sink  msg,
  ftvp_rec_if.source rec
);

  typedef enum logic [2:0] {
    PH_TAG8,
    PH_TAG9,
    PH_TAG35,
    PH_BODY,
    PH_DRAIN
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [7:0]         running_sum, running_sum_next;
  logic [7:0]         sum_at_field_start, sum_at_field_start_next;
  logic [TAG_W-1:0]   tag_accumulator, tag_accumulator_next;
  logic               tag_valid, tag_valid_next;
  logic               in_value, in_value_next;
  logic [POS_W-1:0]   value_start, value_start_next;
  logic [NUM_W-1:0]   value_accumulator, value_accumulator_next;
  logic               value_valid, value_valid_next;
  logic               value_negative, value_negative_next;
  logic [NUM_W-1:0]   length_register, length_register_next;

  rec_t               q [Q_DEPTH];
  rec_t               q_next [Q_DEPTH];
  logic [Q_CNT_W-1:0] count, count_next;

  logic               accept, pop;
  logic               is_digit;
  logic [3:0]         digit;
  logic [TAG_W+3:0]   tag_prod;
  logic [NUM_W+3:0]   value_prod;
  logic [NUM_W+3:0]   value_limit;
  logic [POS_W-1:0]   field_len;
  logic               field_ok;
  logic [NUM_W-1:0]   field_num;
  logic               field_hit, status_hit, do_reset;
  logic [2:0]         status_code;
  logic [7:0]         cs_comp;
  logic [NUM_W-1:0]   cs_recv;
  rec_t               field_rec, status_rec, first_rec;
  logic [1:0]         n_push;
  logic [Q_CNT_W-1:0] base, base_p1;

  function automatic logic [2:0] fail_code(phase_t p);
    logic [2:0] c;
    unique case (p)
      PH_TAG8:  c = ST_NO_BEGIN;
      PH_TAG9:  c = ST_NO_BODY_LEN;
      PH_TAG35: c = ST_BAD_FORMAT;
      default:  c = ST_NO_CHECKSUM;
    endcase
    return c;
  endfunction

  assign msg.ready = (count <= Q_CNT_W'(Q_DEPTH - 2));
  assign accept    = msg.valid && msg.ready;
  assign pop       = rec.valid && rec.ready;

  assign is_digit    = (msg.data_byte >= CH_ZERO) && (msg.data_byte <= CH_NINE);
  assign digit       = 4'(msg.data_byte - CH_ZERO);
  assign tag_prod    = (TAG_W+4)'(tag_accumulator) * (TAG_W+4)'(10) + (TAG_W+4)'(digit);
  assign value_prod  = (NUM_W+4)'(value_accumulator) * (NUM_W+4)'(10) + (NUM_W+4)'(digit);
  assign value_limit = value_negative ? (NUM_W+4)'(36'h0_8000_0000)
                                      : (NUM_W+4)'(36'h0_7FFF_FFFF);
  assign field_len   = byte_position - value_start;
  assign field_ok    = value_valid && (field_len > (value_negative ? POS_W'(1) : POS_W'(0)));
  assign field_num   = !field_ok       ? '0 :
                       value_negative ? (NUM_W'(0) - value_accumulator) : value_accumulator;

  always_comb begin
    phase_next              = phase;
    byte_position_next      = byte_position;
    running_sum_next        = running_sum;
    sum_at_field_start_next = sum_at_field_start;
    tag_accumulator_next    = tag_accumulator;
    tag_valid_next          = tag_valid;
    in_value_next           = in_value;
    value_start_next        = value_start;
    value_accumulator_next  = value_accumulator;
    value_valid_next        = value_valid;
    value_negative_next     = value_negative;
    length_register_next    = length_register;
    field_hit               = 1'b0;
    status_hit              = 1'b0;
    status_code             = ST_OK;
    do_reset                = 1'b0;
    cs_comp                 = '0;
    cs_recv                 = '0;

    if (accept) begin
      if (phase == PH_DRAIN) begin
        do_reset = msg.end_of_buffer;
      end else begin
        running_sum_next = running_sum + msg.data_byte;
        if (byte_position != POS_W'(MAX_MESSAGE_BYTES)) begin
          byte_position_next = byte_position + POS_W'(1);
        end

        if (byte_position >= POS_W'(MAX_MESSAGE_BYTES)) begin
          status_hit  = 1'b1;
          status_code = ST_BAD_FORMAT;
        end else if (!in_value) begin
          if (is_digit) begin
            if (tag_prod > (TAG_W+4)'(TAG_MAX)) begin
              status_hit  = 1'b1;
              status_code = fail_code(phase);
            end else begin
              tag_accumulator_next = tag_prod[TAG_W-1:0];
              tag_valid_next       = 1'b1;
            end
          end else if (msg.data_byte == CH_EQ && tag_valid) begin
            if ((phase == PH_TAG8 && tag_accumulator != TAG_BEGIN) ||
                (phase == PH_TAG9 && tag_accumulator != TAG_BODY_LEN) ||
                (phase == PH_TAG35 && tag_accumulator != TAG_MSG_TYPE)) begin
              status_hit  = 1'b1;
              status_code = fail_code(phase);
            end else begin
              in_value_next          = 1'b1;
              value_start_next       = byte_position + POS_W'(1);
              value_accumulator_next = '0;
              value_valid_next       = 1'b1;
              value_negative_next    = 1'b0;
            end
          end else begin
            status_hit  = 1'b1;
            status_code = fail_code(phase);
          end
        end else if (msg.data_byte == CH_SOH) begin
          field_hit = 1'b1;
          unique case (phase)
            PH_TAG8:  phase_next = PH_TAG9;
            PH_TAG9: begin
              if (!field_ok) begin
                status_hit  = 1'b1;
                status_code = ST_BAD_FORMAT;
              end else begin
                length_register_next = field_num;
                phase_next           = PH_TAG35;
              end
            end
            PH_TAG35: phase_next = PH_BODY;
            default: begin
              if (tag_accumulator == TAG_CHECKSUM) begin
                cs_comp     = sum_at_field_start;
                cs_recv     = field_num;
                status_hit  = 1'b1;
                status_code = (NUM_W'(cs_comp) == cs_recv) ? ST_OK : ST_BAD_CHECKSUM;
              end
            end
          endcase
          tag_accumulator_next    = '0;
          tag_valid_next          = 1'b0;
          in_value_next           = 1'b0;
          sum_at_field_start_next = running_sum_next;
        end else if (value_valid) begin
          if (byte_position == value_start && msg.data_byte == CH_MINUS) begin
            value_negative_next = 1'b1;
          end else if (is_digit) begin
            if (value_prod > value_limit) begin
              value_valid_next = 1'b0;
            end else begin
              value_accumulator_next = value_prod[NUM_W-1:0];
            end
          end else begin
            value_valid_next = 1'b0;
          end
        end

        if (!status_hit && msg.end_of_buffer) begin
          status_hit  = 1'b1;
          status_code = fail_code(phase_next);
        end
        if (status_hit) begin
          if (msg.end_of_buffer) begin
            do_reset = 1'b1;
          end else begin
            phase_next = PH_DRAIN;
          end
        end
      end
    end

    field_rec                   = '0;
    field_rec.record_kind       = KIND_FIELD;
    field_rec.field_tag         = tag_accumulator;
    field_rec.value_offset      = OFFSET_W'(value_start);
    field_rec.value_length      = LEN_W'(field_len);
    field_rec.value_number      = field_num;
    field_rec.number_ok         = field_ok;
    field_rec.last_result       = !status_hit;

    status_rec                   = '0;
    status_rec.record_kind       = KIND_STATUS;
    status_rec.status            = status_code;
    status_rec.stated_length     = length_register_next;
    status_rec.computed_checksum = cs_comp;
    status_rec.received_checksum = cs_recv;
    status_rec.last_result       = 1'b1;

    if (do_reset) begin
      phase_next              = PH_TAG8;
      byte_position_next      = '0;
      running_sum_next        = '0;
      sum_at_field_start_next = '0;
      tag_accumulator_next    = '0;
      tag_valid_next          = 1'b0;
      in_value_next           = 1'b0;
      value_start_next        = '0;
      value_accumulator_next  = '0;
      value_valid_next        = 1'b0;
      value_negative_next     = 1'b0;
      length_register_next    = '0;
    end
  end

  assign first_rec = field_hit ? field_rec : status_rec;
  assign n_push    = {1'b0, field_hit} + {1'b0, status_hit};
  assign base      = count - Q_CNT_W'(pop);
  assign base_p1   = base + Q_CNT_W'(1);

  always_comb begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
    end
    if (n_push != 2'd0) begin
      q_next[base[Q_IDX_W-1:0]] = first_rec;
    end
    if (n_push == 2'd2) begin
      q_next[base_p1[Q_IDX_W-1:0]] = status_rec;
    end
    count_next = base + Q_CNT_W'(n_push);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
    if (rst) begin
      phase              <= PH_TAG8;
      byte_position      <= '0;
      running_sum        <= '0;
      sum_at_field_start <= '0;
      tag_accumulator    <= '0;
      tag_valid          <= 1'b0;
      in_value           <= 1'b0;
      value_start        <= '0;
      value_accumulator  <= '0;
      value_valid        <= 1'b0;
      value_negative     <= 1'b0;
      length_register    <= '0;
      count              <= '0;
    end else begin
      phase              <= phase_next;
      byte_position      <= byte_position_next;
      running_sum        <= running_sum_next;
      sum_at_field_start <= sum_at_field_start_next;
      tag_accumulator    <= tag_accumulator_next;
      tag_valid          <= tag_valid_next;
      in_value           <= in_value_next;
      value_start        <= value_start_next;
      value_accumulator  <= value_accumulator_next;
      value_valid        <= value_valid_next;
      value_negative     <= value_negative_next;
      length_register    <= length_register_next;
      count              <= count_next;
    end
  end

  assign rec.valid             = (count != '0);
  assign rec.record_kind       = q[0].record_kind;
  assign rec.field_tag         = q[0].field_tag;
  assign rec.value_offset      = q[0].value_offset;
  assign rec.value_length      = q[0].value_length;
  assign rec.value_number      = q[0].value_number;
  assign rec.number_ok         = q[0].number_ok;
  assign rec.status            = q[0].status;
  assign rec.stated_length     = q[0].stated_length;
  assign rec.computed_checksum = q[0].computed_checksum;
  assign rec.received_checksum = q[0].received_checksum;
  assign rec.last_result       = q[0].last_result;

endmodule
